>>> design/spmrf_pkg.sv
// Package for the SPI master register block: sizes, register layout, types and helpers.
package spmrf_pkg;

  // Sizes
  localparam int FIFO_DEPTH = 8;
  localparam int CS_LINES   = 1;
  localparam int DATA_W     = 8;
  localparam int WORD_W     = 32;
  localparam int REPLY_W    = 64;
  localparam int OFF_W      = 3;
  localparam int CS_W       = 3;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Access codes
  localparam logic       FUNC_READ  = 1'b0;
  localparam logic       FUNC_WRITE = 1'b1;
  localparam logic [OFF_W-1:0] OFF_CTRL = 3'd0;
  localparam logic [OFF_W-1:0] OFF_DATA = 3'd4;

  // Byte substitution on data writes
  localparam logic [DATA_W-1:0] BYTE_ESC = 8'hAB;
  localparam logic [DATA_W-1:0] BYTE_SUB = 8'h00;

  // Control register bit positions
  localparam int B_EN     = 0;
  localparam int B_CSSEL1 = 4;
  localparam int B_CSSEL2 = 5;
  localparam int B_CSEN   = 6;
  localparam int B_RXAV   = 16;
  localparam int B_TXEMPT = 17;
  localparam int B_TXHALF = 18;
  localparam int B_TXFULL = 19;
  localparam int B_IRQRX  = 20;
  localparam int B_IRQTXE = 21;
  localparam int B_IRQTXH = 22;
  localparam int B_SIZE   = 23;
  localparam int B_BUSY   = 31;

  function automatic int floor_log2(int d);
    int n;
    n = 0;
    for (int i = 1; i <= 4; i++) begin
      if (d >= (1 << i)) n = i;
    end
    return n;
  endfunction

  localparam logic [WORD_W-1:0] SIZE_MASK   = 32'hF << B_SIZE;
  localparam logic [WORD_W-1:0] SIZE_VAL    = 32'(floor_log2(FIFO_DEPTH) % 16) << B_SIZE;
  localparam logic [WORD_W-1:0] STATUS_MASK = (32'h1 << B_RXAV) | (32'h1 << B_TXEMPT) |
                                              (32'h1 << B_TXHALF) | (32'h1 << B_TXFULL) |
                                              (32'h1 << B_BUSY);
  localparam logic [WORD_W-1:0] WRITABLE    = ~(STATUS_MASK | SIZE_MASK);
  localparam logic [CNT_W-1:0]  HALF_CNT    = CNT_W'(FIFO_DEPTH / 2);
  localparam logic [CNT_W-1:0]  FULL_CNT    = CNT_W'(FIFO_DEPTH);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } fifo_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] sent_byte;
    logic              sent_valid;
    logic [WORD_W-1:0] read_data;
    logic              irq_line;
    logic [CS_W-1:0]   chip_selects_n;
    logic              access_error;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_DRAIN
  } seq_state_t;

  function automatic logic irq_calc(logic [WORD_W-1:0] ctrl, logic rx_nonempty,
                                    logic [CNT_W-1:0] tx_count);
    logic rx, te, th;
    rx = ctrl[B_IRQRX] && rx_nonempty;
    te = ctrl[B_IRQTXE] && (tx_count == '0);
    th = ctrl[B_IRQTXH] && (tx_count < HALF_CNT);
    return rx || te || th;
  endfunction

  function automatic logic [CS_W-1:0] chip_sel_calc(logic [WORD_W-1:0] ctrl);
    logic [1:0]      idx;
    logic [CS_W-1:0] lines;
    idx   = ctrl[B_CSSEL2] ? 2'd2 : (ctrl[B_CSSEL1] ? 2'd1 : 2'd0);
    lines = '1;
    if (ctrl[B_CSEN] && (int'(idx) < CS_LINES)) lines[idx] = 1'b0;
    return lines;
  endfunction

  function automatic logic [WORD_W-1:0] control_view(logic [WORD_W-1:0] ctrl,
                                                     logic rx_nonempty,
                                                     logic [CNT_W-1:0] tx_count);
    logic [WORD_W-1:0] v;
    v = (ctrl & WRITABLE) | SIZE_VAL;
    v[B_RXAV]   = rx_nonempty;
    v[B_TXEMPT] = (tx_count == '0);
    v[B_TXHALF] = (tx_count < HALF_CNT);
    v[B_TXFULL] = (tx_count >= FULL_CNT);
    v[B_BUSY]   = (tx_count != '0);
    return v;
  endfunction

endpackage

>>> design/spmrf_if.sv
// Handshake interfaces for the bus access channel and the result channel.
interface spmrf_in_if;
  import spmrf_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [OFF_W-1:0]   offset;
  logic [WORD_W-1:0]  write_data;
  logic [REPLY_W-1:0] slave_replies;

  modport source (output valid, func, offset, write_data, slave_replies, input ready);
  modport sink   (input valid, func, offset, write_data, slave_replies, output ready);
endinterface

interface spmrf_out_if;
  import spmrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sent_byte;
  logic              sent_valid;
  logic [WORD_W-1:0] read_data;
  logic              irq_line;
  logic [CS_W-1:0]   chip_selects_n;
  logic              access_error;
  logic              last;

  modport source (output valid, sent_byte, sent_valid, read_data, irq_line,
                  chip_selects_n, access_error, last, input ready);
  modport sink   (input valid, sent_byte, sent_valid, read_data, irq_line,
                  chip_selects_n, access_error, last, output ready);
endinterface

>>> design/spi_master_register_fifo.sv
// Top level: bus access sequencer, control register and the transmit and receive queues.
// An access is captured, carried out, then answered by a registered result word; while the
//   transmit queue drains, one further word follows in each cycle that the sink takes one.
// A new access is taken only once the last result word is loaded; a data write that shifts
//   out bytes drains the whole queue, up to its depth, one byte a cycle while the slot is free.
// Reset (synchronous, active low): control reads zero but for the size and TX-empty/half bits;
//   both queues are empty, no result is pending; queue contents are not cleared.
module spi_master_register_fifo (
  input  logic        clk,
  input  logic        rst_n,
  spmrf_in_if.sink    in_chan,
  spmrf_out_if.source out_chan
);
  import spmrf_pkg::*;

  seq_state_t state_r, state_nxt;

  // Captured access
  logic               func_r, func_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [WORD_W-1:0]  wd_r, wd_nxt;
  logic [REPLY_W-1:0] rep_r, rep_nxt;

  // Outcome of the access, held until the single result word is built
  logic [WORD_W-1:0]  rd_r, rd_nxt;
  logic               err_r, err_nxt;

  // Only the writable bits are stored; status and size are merged on read.
  logic [WORD_W-1:0]  ctrl_r, ctrl_nxt;

  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;

  logic               tx_push, tx_pop, rx_push, rx_pop;
  logic [DATA_W-1:0]  tx_push_data, tx_pop_data, rx_push_data, rx_pop_data;
  fifo_stat_t         tx_stat, rx_stat;

  spmrf_fifo u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tx_push),
    .push_data (tx_push_data),
    .pop       (tx_pop),
    .pop_data  (tx_pop_data),
    .stat      (tx_stat)
  );

  spmrf_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rx_push),
    .push_data (rx_push_data),
    .pop       (rx_pop),
    .pop_data  (rx_pop_data),
    .stat      (rx_stat)
  );

  // The output register frees its slot in the same cycle the sink takes the word,
  // so the sequencer can load the next word without a bubble.
  assign slot_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready = (state_r == ST_IDLE);

  // The byte written is the low byte of the data, with the escape byte replaced.
  assign tx_push_data = (wd_r[DATA_W-1:0] == BYTE_ESC) ? BYTE_SUB : wd_r[DATA_W-1:0];
  // Replies are consumed from the bottom; the register shifts down one byte per transfer.
  assign rx_push_data = rep_r[DATA_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    off_nxt       = off_r;
    wd_nxt        = wd_r;
    rep_nxt       = rep_r;
    rd_nxt        = rd_r;
    err_nxt       = err_r;
    ctrl_nxt      = ctrl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    tx_push       = 1'b0;
    tx_pop        = 1'b0;
    rx_push       = 1'b0;
    rx_pop        = 1'b0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          func_nxt  = in_chan.func;
          off_nxt   = in_chan.offset;
          wd_nxt    = in_chan.write_data;
          rep_nxt   = in_chan.slave_replies;
          state_nxt = ST_EXEC;
        end
      end

      // Carry out the register access itself.
      ST_EXEC: begin
        rd_nxt    = '0;
        err_nxt   = 1'b0;
        state_nxt = ST_RESP;
        if (func_r == FUNC_READ) begin
          if (off_r == OFF_CTRL) begin
            rd_nxt = control_view(ctrl_r, !rx_stat.empty, tx_stat.count);
          end else if (off_r == OFF_DATA) begin
            // An empty receive queue reads as zero.
            if (!rx_stat.empty) begin
              rd_nxt = {{(WORD_W - DATA_W){1'b0}}, rx_pop_data};
              rx_pop = 1'b1;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end else begin
          if (off_r == OFF_CTRL) begin
            ctrl_nxt = wd_r & WRITABLE;
          end else if (off_r == OFF_DATA) begin
            if (tx_stat.full) begin
              err_nxt = 1'b1;
            end else begin
              tx_push = 1'b1;
              if (ctrl_r[B_EN]) state_nxt = ST_DRAIN;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
      end

      // Single result word for an access that shifts nothing out.
      ST_RESP: begin
        if (slot_free) begin
          out_nxt.sent_byte      = '0;
          out_nxt.sent_valid     = 1'b0;
          out_nxt.read_data      = rd_r;
          out_nxt.irq_line       = irq_calc(ctrl_r, !rx_stat.empty, tx_stat.count);
          out_nxt.chip_selects_n = chip_sel_calc(ctrl_r);
          out_nxt.access_error   = err_r;
          out_nxt.last           = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end

      // Shift out one byte in each cycle that the output slot is free, until the transmit queue
      // is empty. Each word carries the interrupt level as it will be after the drain: the transmit
      // queue empty and the receive queue holding at least one byte.
      ST_DRAIN: begin
        if (slot_free) begin
          tx_pop                 = 1'b1;
          rx_push                = 1'b1;
          rep_nxt                = rep_r >> DATA_W;
          out_nxt.sent_byte      = tx_pop_data;
          out_nxt.sent_valid     = 1'b1;
          out_nxt.read_data      = '0;
          out_nxt.irq_line       = irq_calc(ctrl_r, 1'b1, '0);
          out_nxt.chip_selects_n = chip_sel_calc(ctrl_r);
          out_nxt.access_error   = 1'b0;
          out_nxt.last           = (tx_stat.count == CNT_W'(1));
          out_valid_nxt          = 1'b1;
          if (tx_stat.count == CNT_W'(1)) state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctrl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    off_r  <= off_nxt;
    wd_r   <= wd_nxt;
    rep_r  <= rep_nxt;
    rd_r   <= rd_nxt;
    err_r  <= err_nxt;
    out_r  <= out_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.sent_byte      = out_r.sent_byte;
  assign out_chan.sent_valid     = out_r.sent_valid;
  assign out_chan.read_data      = out_r.read_data;
  assign out_chan.irq_line       = out_r.irq_line;
  assign out_chan.chip_selects_n = out_r.chip_selects_n;
  assign out_chan.access_error   = out_r.access_error;
  assign out_chan.last           = out_r.last;

endmodule

>>> design/spmrf_fifo.sv
// Byte queue with head pointer and fill count; pushes to a full queue are dropped.
module spmrf_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [spmrf_pkg::DATA_W-1:0] push_data,
  input  logic                      pop,
  output logic [spmrf_pkg::DATA_W-1:0] pop_data,
  output spmrf_pkg::fifo_stat_t     stat
);
  import spmrf_pkg::*;

  localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W + 1)'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

  logic [DATA_W-1:0] slot_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic              do_push, do_pop;

  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Tail index: the count is below the depth whenever a push is taken.
  always_comb begin
    tail_sum = {1'b0, head_r} + {1'b0, count_r[PTR_W-1:0]};
    if (tail_sum >= DEPTH_P) tail_sum = tail_sum - DEPTH_P;
    tail = tail_sum[PTR_W-1:0];
  end

  always_comb begin
    head_nxt = head_r;
    if (do_pop) head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  assign pop_data = slot_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[tail] <= push_data;
  end

endmodule

>>> design/spmrf_checker.sv
// Port-level checks on the SPI master register block, bound to its top level.
module spmrf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic [spmrf_pkg::DATA_W-1:0] out_sent_byte,
  input logic                         out_sent_valid,
  input logic                         out_last
);
  import spmrf_pkg::*;

  // A word is never shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

  // An accepted access keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new access accepted in the cycle after another");

  // A word without a transferred byte is the only word of its access.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sent_valid) |-> (out_last && out_sent_byte == '0))
    else $error("word without transfer is not last or carries a byte");

  // While the block takes accesses, any pending word closes the previous access.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_last)
    else $error("new access possible before the drain has finished");

endmodule

bind spi_master_register_fifo spmrf_checker u_spmrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_sent_byte  (out_chan.sent_byte),
  .out_sent_valid (out_chan.sent_valid),
  .out_last       (out_chan.last)
);
